[hw/rtl/cacc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cacc_pkg
// Shared types and constants of the chain atom clash checker.
// ----------------------------------------------------------------------------
package cacc_pkg;

    // sizing of the atom store and the radius table
    localparam int MAX_ATOMS   = 1024;
    localparam int NUM_KINDS   = 3;
    localparam int COORD_BITS  = 24;
    localparam int ADDR_W      = $clog2(MAX_ATOMS);
    localparam int CLASS_COUNT = 3;
    localparam int TABLE_SIZE  = NUM_KINDS * NUM_KINDS * CLASS_COUNT;
    localparam int TBL_IDX_W   = $clog2(TABLE_SIZE);

    // fixed field widths of the item
    localparam int POS_W   = 10;
    localparam int KIND_W  = 2;
    localparam int CLS_W   = 2;
    localparam int LIMIT_W = 32;

    // datapath widths
    localparam int DIFF_W = COORD_BITS + 1;
    localparam int ABS_W  = 16;
    localparam int SQ_W   = 2 * ABS_W;
    localparam int SUM_W  = SQ_W + 2;

    // closest chain separation that is checked
    localparam int MIN_SEP = 3;

    // item commands
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_PLACE = 1'b1;

    // separation classes
    localparam logic [CLS_W-1:0] CLS_14  = 2'd0;
    localparam logic [CLS_W-1:0] CLS_15  = 2'd1;
    localparam logic [CLS_W-1:0] CLS_FAR = 2'd2;

    // one stored atom
    typedef struct packed {
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
        logic signed [COORD_BITS-1:0] z;
        logic [KIND_W-1:0]            kind;
    } t_atom;

    // control that travels with one pair through the distance pipe
    typedef struct packed {
        logic vld;
        logic last;
    } t_pair_tag;

    // per-pair result at the tail of the distance pipe
    typedef struct packed {
        logic vld;
        logic last;
        logic hit;
    } t_pair_res;

    // sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_DONE
    } t_state;

endpackage
`default_nettype wire

[hw/rtl/cacc_atom_mem.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cacc_atom_mem
// Single-port-write, single-port-read atom store with registered read data.
// ----------------------------------------------------------------------------
module cacc_atom_mem (
    input  wire logic                        i_clk,
    input  wire logic                        i_we,
    input  wire logic [cacc_pkg::ADDR_W-1:0] i_waddr,
    input  wire cacc_pkg::t_atom             i_wdata,
    input  wire logic [cacc_pkg::ADDR_W-1:0] i_raddr,
    output cacc_pkg::t_atom                  o_rdata
);
    import cacc_pkg::*;

    t_atom r_mem [MAX_ATOMS];
    t_atom r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, registered
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

[hw/rtl/cacc_radius_table.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cacc_radius_table
// Squared clash radius per kind pair and separation class, cleared on reset.
// ----------------------------------------------------------------------------
module cacc_radius_table (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_we,
    input  wire logic [cacc_pkg::KIND_W-1:0]  i_wr_kind,
    input  wire logic [cacc_pkg::KIND_W-1:0]  i_wr_partner,
    input  wire logic [cacc_pkg::CLS_W-1:0]   i_wr_cls,
    input  wire logic [cacc_pkg::LIMIT_W-1:0] i_wr_value,
    input  wire logic [cacc_pkg::KIND_W-1:0]  i_rd_kind,
    input  wire logic [cacc_pkg::KIND_W-1:0]  i_rd_partner,
    input  wire logic [cacc_pkg::CLS_W-1:0]   i_rd_cls,
    output logic      [cacc_pkg::LIMIT_W-1:0] o_rd_value
);
    import cacc_pkg::*;

    logic [LIMIT_W-1:0] r_tbl [TABLE_SIZE];
    logic               w_wr_ok;
    logic               w_rd_ok;
    logic [TBL_IDX_W-1:0] w_wr_idx;
    logic [TBL_IDX_W-1:0] w_rd_idx;

    function automatic logic in_range(
        input logic [KIND_W-1:0] a,
        input logic [KIND_W-1:0] b,
        input logic [CLS_W-1:0]  c
    );
        return (32'(a) < NUM_KINDS) && (32'(b) < NUM_KINDS) && (32'(c) < CLASS_COUNT);
    endfunction

    function automatic logic [TBL_IDX_W-1:0] tbl_index(
        input logic [KIND_W-1:0] a,
        input logic [KIND_W-1:0] b,
        input logic [CLS_W-1:0]  c
    );
        int idx;
        idx = (32'(a) * NUM_KINDS + 32'(b)) * CLASS_COUNT + 32'(c);
        return TBL_IDX_W'(idx);
    endfunction

    // index decode for both ports
    always_comb begin
        w_wr_ok  = in_range(i_wr_kind, i_wr_partner, i_wr_cls);
        w_rd_ok  = in_range(i_rd_kind, i_rd_partner, i_rd_cls);
        w_wr_idx = tbl_index(i_wr_kind, i_wr_partner, i_wr_cls);
        w_rd_idx = tbl_index(i_rd_kind, i_rd_partner, i_rd_cls);
    end

    // table entries, out-of-range writes dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < TABLE_SIZE; i++) begin
                r_tbl[i] <= '0;
            end
        end else if (i_we && w_wr_ok) begin
            r_tbl[w_wr_idx] <= i_wr_value;
        end
    end

    // a pair with an unknown kind never clashes
    assign o_rd_value = w_rd_ok ? r_tbl[w_rd_idx] : '0;

endmodule
`default_nettype wire

[hw/rtl/cacc_dist_pipe.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cacc_dist_pipe
// Three-stage squared distance compare: abs difference, squares, sum and test.
// ----------------------------------------------------------------------------
module cacc_dist_pipe (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire cacc_pkg::t_pair_tag                    i_tag,
    input  wire logic signed [cacc_pkg::COORD_BITS-1:0] i_cur_x,
    input  wire logic signed [cacc_pkg::COORD_BITS-1:0] i_cur_y,
    input  wire logic signed [cacc_pkg::COORD_BITS-1:0] i_cur_z,
    input  wire cacc_pkg::t_atom                        i_atom,
    input  wire logic [cacc_pkg::LIMIT_W-1:0]           i_thr,
    output cacc_pkg::t_pair_res                         o_res
);
    import cacc_pkg::*;

    function automatic logic [DIFF_W-1:0] abs_diff(
        input logic signed [COORD_BITS-1:0] a,
        input logic signed [COORD_BITS-1:0] b
    );
        logic signed [DIFF_W-1:0] d;
        d = DIFF_W'(a) - DIFF_W'(b);
        return d[DIFF_W-1] ? DIFF_W'(-d) : DIFF_W'(d);
    endfunction

    logic [DIFF_W-1:0]  w_ax;
    logic [DIFF_W-1:0]  w_ay;
    logic [DIFF_W-1:0]  w_az;
    logic               w_far;

    // stage 1 registers
    t_pair_tag          r_s1_tag;
    logic [ABS_W-1:0]   r_s1_ax;
    logic [ABS_W-1:0]   r_s1_ay;
    logic [ABS_W-1:0]   r_s1_az;
    logic               r_s1_far;
    logic [LIMIT_W-1:0] r_s1_thr;

    // stage 2 registers
    t_pair_tag          r_s2_tag;
    logic [SQ_W-1:0]    r_s2_sx;
    logic [SQ_W-1:0]    r_s2_sy;
    logic [SQ_W-1:0]    r_s2_sz;
    logic               r_s2_far;
    logic [LIMIT_W-1:0] r_s2_thr;

    // stage 3 register
    t_pair_res          r_s3_res;
    logic [SUM_W-1:0]   w_sum;

    // absolute differences; any axis at or above 2^16 puts the pair out of reach
    always_comb begin
        w_ax  = abs_diff(i_cur_x, i_atom.x);
        w_ay  = abs_diff(i_cur_y, i_atom.y);
        w_az  = abs_diff(i_cur_z, i_atom.z);
        w_far = (64'(w_ax) >= 64'd65536) || (64'(w_ay) >= 64'd65536)
             || (64'(w_az) >= 64'd65536);
    end

    // valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_tag <= '0;
            r_s2_tag <= '0;
            r_s3_res <= '0;
        end else begin
            r_s1_tag     <= i_tag;
            r_s2_tag     <= r_s1_tag;
            r_s3_res.vld <= r_s2_tag.vld;
            r_s3_res.last <= r_s2_tag.last;
            r_s3_res.hit <= r_s2_tag.vld && !r_s2_far && (w_sum < SUM_W'(r_s2_thr));
        end
    end

    // payload stages
    always_ff @(posedge i_clk) begin
        r_s1_ax  <= ABS_W'(w_ax);
        r_s1_ay  <= ABS_W'(w_ay);
        r_s1_az  <= ABS_W'(w_az);
        r_s1_far <= w_far;
        r_s1_thr <= i_thr;

        r_s2_sx  <= SQ_W'(r_s1_ax) * SQ_W'(r_s1_ax);
        r_s2_sy  <= SQ_W'(r_s1_ay) * SQ_W'(r_s1_ay);
        r_s2_sz  <= SQ_W'(r_s1_az) * SQ_W'(r_s1_az);
        r_s2_far <= r_s1_far;
        r_s2_thr <= r_s1_thr;
    end

    // sum of squares
    assign w_sum = SUM_W'(r_s2_sx) + SUM_W'(r_s2_sy) + SUM_W'(r_s2_sz);

    assign o_res = r_s3_res;

endmodule
`default_nettype wire

[hw/rtl/chain_atom_clash_check_top.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// chain_atom_clash_check_top
// Stores placed atoms and checks each new one against all earlier atoms at
// least three chain positions back.
//
//   channel  | handshake            | payload
//   ---------+----------------------+------------------------------------------
//   input    | i_valid / o_stall    | cmd, position, coords, kinds, class, limit
//   output   | o_valid / i_stall    | clash
//
// A table write, or a placement below position 3, goes straight to the done state.
// A placement at position p reads the atom store once per earlier atom it is
// checked against (p - 2 reads), then lets the distance pipe drain.
// Reset clears the radius table and control; the atom store is not cleared.
// The next item is taken while the previous result waits in the output register;
// a further result waits in the done state, and the input stays stalled meanwhile.
// ----------------------------------------------------------------------------
module chain_atom_clash_check_top (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   i_valid,
    output logic                                        o_stall,
    input  wire logic                                   i_cmd,
    input  wire logic [cacc_pkg::POS_W-1:0]             i_position,
    input  wire logic signed [cacc_pkg::COORD_BITS-1:0] i_coord_x,
    input  wire logic signed [cacc_pkg::COORD_BITS-1:0] i_coord_y,
    input  wire logic signed [cacc_pkg::COORD_BITS-1:0] i_coord_z,
    input  wire logic [cacc_pkg::KIND_W-1:0]            i_kind,
    input  wire logic [cacc_pkg::KIND_W-1:0]            i_partner_kind,
    input  wire logic [cacc_pkg::CLS_W-1:0]             i_sep_class,
    input  wire logic [cacc_pkg::LIMIT_W-1:0]           i_limit_value,
    output logic                                        o_valid,
    input  wire logic                                   i_stall,
    output logic                                        o_clash
);
    import cacc_pkg::*;

    t_state r_state;
    t_state n_state;

    // scan control
    logic [ADDR_W-1:0] r_k;
    logic [ADDR_W-1:0] n_k;
    logic [ADDR_W-1:0] r_last;
    logic [ADDR_W-1:0] n_last;
    logic              r_hit;
    logic              n_hit;

    // placed atom under check
    logic signed [COORD_BITS-1:0] r_cur_x;
    logic signed [COORD_BITS-1:0] r_cur_y;
    logic signed [COORD_BITS-1:0] r_cur_z;
    logic [KIND_W-1:0]            r_cur_kind;

    // read tag aligned with memory read data
    t_pair_tag        r_rd_tag;
    logic [CLS_W-1:0] r_rd_cls;

    // output register
    logic r_out_valid;
    logic n_out_valid;
    logic r_out_clash;
    logic n_out_clash;

    // decoded item
    logic              w_accept;
    logic              w_place_ok;
    logic              w_place_scan;
    logic [ADDR_W-1:0] w_addr;

    // memory and table hookup
    logic              w_mem_we;
    logic              w_tbl_we;
    logic              w_issue;
    logic              w_out_free;
    t_atom             w_wdata;
    t_atom             w_rdata;
    logic [LIMIT_W-1:0] w_thr;
    t_pair_tag         w_issue_tag;
    logic [CLS_W-1:0]  w_issue_cls;
    t_pair_res         w_res;

    // item decode
    always_comb begin
        w_accept     = i_valid && !o_stall;
        w_addr       = ADDR_W'(i_position);
        w_place_ok   = (i_cmd == CMD_PLACE) && (32'(i_position) < MAX_ATOMS);
        w_place_scan = w_place_ok && (32'(i_position) >= MIN_SEP);
        w_out_free   = !r_out_valid || !i_stall;
        w_wdata.x    = i_coord_x;
        w_wdata.y    = i_coord_y;
        w_wdata.z    = i_coord_z;
        w_wdata.kind = i_kind;
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = w_place_scan ? S_SCAN : S_DONE;
                end
            end
            S_SCAN: begin
                if (r_k == r_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (w_res.vld && w_res.last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_stall  = (r_state != S_IDLE);
        w_mem_we = (r_state == S_IDLE) && w_accept && w_place_ok;
        w_tbl_we = (r_state == S_IDLE) && w_accept && (i_cmd == CMD_WRITE);
        w_issue  = (r_state == S_SCAN);
    end

    // read issue tag and class
    always_comb begin
        w_issue_tag.vld  = w_issue;
        w_issue_tag.last = w_issue && (r_k == r_last);
        priority if (r_k == r_last) begin
            w_issue_cls = CLS_14;
        end else if (r_k + ADDR_W'(1) == r_last) begin
            w_issue_cls = CLS_15;
        end else begin
            w_issue_cls = CLS_FAR;
        end
    end

    // datapath next values
    always_comb begin
        n_k         = r_k;
        n_last      = r_last;
        n_hit       = r_hit;
        n_out_valid = r_out_valid && i_stall;
        n_out_clash = r_out_clash;
        if (w_accept) begin
            n_k    = '0;
            n_last = w_addr - ADDR_W'(MIN_SEP);
            n_hit  = 1'b0;
        end
        if (w_issue) begin
            n_k = r_k + ADDR_W'(1);
        end
        if (w_res.vld && w_res.hit) begin
            n_hit = 1'b1;
        end
        if ((r_state == S_DONE) && w_out_free) begin
            n_out_valid = 1'b1;
            n_out_clash = r_hit;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_rd_tag    <= '0;
            r_hit       <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_rd_tag    <= w_issue_tag;
            r_hit       <= n_hit;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_k         <= n_k;
        r_last      <= n_last;
        r_rd_cls    <= w_issue_cls;
        r_out_clash <= n_out_clash;
        if (w_accept) begin
            r_cur_x    <= i_coord_x;
            r_cur_y    <= i_coord_y;
            r_cur_z    <= i_coord_z;
            r_cur_kind <= i_kind;
        end
    end

    // atom store; scan reads only entries at least three below the one written
    cacc_atom_mem u_mem (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_waddr (w_addr),
        .i_wdata (w_wdata),
        .i_raddr (r_k),
        .o_rdata (w_rdata)
    );

    // threshold for the pair leaving the memory
    cacc_radius_table u_tbl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_we         (w_tbl_we),
        .i_wr_kind    (i_kind),
        .i_wr_partner (i_partner_kind),
        .i_wr_cls     (i_sep_class),
        .i_wr_value   (i_limit_value),
        .i_rd_kind    (r_cur_kind),
        .i_rd_partner (w_rdata.kind),
        .i_rd_cls     (r_rd_cls),
        .o_rd_value   (w_thr)
    );

    // squared distance compare
    cacc_dist_pipe u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tag   (r_rd_tag),
        .i_cur_x (r_cur_x),
        .i_cur_y (r_cur_y),
        .i_cur_z (r_cur_z),
        .i_atom  (w_rdata),
        .i_thr   (w_thr),
        .o_res   (w_res)
    );

    assign o_valid = r_out_valid;
    assign o_clash = r_out_clash;

`ifndef NO_ASSERTIONS
    // pair results only arrive while a placement is being checked
    a_res_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res.vld |-> (r_state == S_SCAN || r_state == S_DRAIN))
        else $error("pair result outside of a scan");

    // the scan index never runs past the last earlier atom
    a_k_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_k <= r_last))
        else $error("scan index past last atom");

    // leaving the done state always presents a result
    a_done_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && w_out_free) |=> o_valid)
        else $error("result lost on leaving done state");

    // a finished result is not overwritten while stalled
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_clash)))
        else $error("stalled result changed");
`endif

endmodule
`default_nettype wire

[tb/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Feeds radius-table writes and atom placements into the clash checker. A
// scoreboard keeps its own atom store and radius table, works out the clash
// flag of every accepted item and compares the flags in order. Both channels
// idle at random, and the output is held off once for a long stretch.
// ----------------------------------------------------------------------------
module testbench;
    import cacc_pkg::*;

    localparam int RANDOM_ITEMS = 557;
    localparam int QUIET_ITEMS  = 60;
    localparam int HOLD_AT      = 200;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = MAX_ATOMS + 16;
    localparam int STEP         = 12288;    // 3 A per axis in Q.12
    localparam int COORD_MAX    = (1 << (COORD_BITS - 1)) - 1;
    localparam int COORD_MIN    = -(1 << (COORD_BITS - 1));

    localparam logic [KIND_W-1:0]  KIND_BAD  = 2'd3;
    localparam logic [CLS_W-1:0]   CLS_BAD   = 2'd3;
    localparam logic [LIMIT_W-1:0] LIMIT_MAX = 32'hFFFF_FFFF;
    localparam logic [LIMIT_W-1:0] ONE_SQ_A  = 32'h0100_0000;    // 1 A^2 in Q.24

    // one input item
    typedef struct {
        logic                         cmd;
        logic [POS_W-1:0]             position;
        logic signed [COORD_BITS-1:0] coord_x;
        logic signed [COORD_BITS-1:0] coord_y;
        logic signed [COORD_BITS-1:0] coord_z;
        logic [KIND_W-1:0]            kind;
        logic [KIND_W-1:0]            partner_kind;
        logic [CLS_W-1:0]             sep_class;
        logic [LIMIT_W-1:0]           limit_value;
    } t_chain_item;

    // shadow atom store and radius table, plus the queue of pending clash flags
    class clash_scoreboard;
        logic signed [COORD_BITS-1:0] atom_x[MAX_ATOMS];
        logic signed [COORD_BITS-1:0] atom_y[MAX_ATOMS];
        logic signed [COORD_BITS-1:0] atom_z[MAX_ATOMS];
        logic [KIND_W-1:0]            atom_kind[MAX_ATOMS];
        logic [LIMIT_W-1:0]           radius_lut[TABLE_SIZE];
        logic                         expected_clash[$];
        int                           failures;
        int                           results_seen;
        int                           clashes_seen;

        function new();
            foreach (radius_lut[i]) radius_lut[i] = '0;
            failures     = 0;
            results_seen = 0;
            clashes_seen = 0;
        endfunction

        // apply one item to the shadow state and return its clash flag
        function logic predict_clash(t_chain_item it);
            int                  back;
            logic [CLS_W-1:0]    cls;
            logic [LIMIT_W-1:0]  thr;
            longint              dx, dy, dz;
            longint unsigned     ax, ay, az, d2;
            if (it.cmd == CMD_WRITE) begin
                if (it.kind < NUM_KINDS && it.partner_kind < NUM_KINDS &&
                    it.sep_class < CLASS_COUNT) begin
                    radius_lut[(it.kind * NUM_KINDS + it.partner_kind) * CLASS_COUNT +
                               it.sep_class] = it.limit_value;
                end
                return 1'b0;
            end
            atom_x[it.position]    = it.coord_x;
            atom_y[it.position]    = it.coord_y;
            atom_z[it.position]    = it.coord_z;
            atom_kind[it.position] = it.kind;
            if (it.position < MIN_SEP) return 1'b0;
            for (int k = 0; k + MIN_SEP <= int'(it.position); k++) begin
                back = int'(it.position) - k;
                cls  = (back == 3) ? CLS_14 : (back == 4) ? CLS_15 : CLS_FAR;
                // a pair with an unknown kind has a zero threshold
                if (it.kind >= NUM_KINDS || atom_kind[k] >= NUM_KINDS)
                    thr = '0;
                else
                    thr = radius_lut[(it.kind * NUM_KINDS + atom_kind[k]) * CLASS_COUNT + cls];
                dx = longint'(it.coord_x) - longint'(atom_x[k]);
                dy = longint'(it.coord_y) - longint'(atom_y[k]);
                dz = longint'(it.coord_z) - longint'(atom_z[k]);
                ax = (dx < 0) ? -dx : dx;
                ay = (dy < 0) ? -dy : dy;
                az = (dz < 0) ? -dz : dz;
                // any axis this far apart puts the pair beyond every threshold
                if (ax >= 65536 || ay >= 65536 || az >= 65536) continue;
                d2 = ax * ax + ay * ay + az * az;
                if (d2 < longint'(thr)) return 1'b1;
            end
            return 1'b0;
        endfunction

        function void note_item(t_chain_item it);
            expected_clash.push_back(predict_clash(it));
        endfunction

        function void flag_error(string what, logic want, logic got);
            failures++;
            if (failures <= 10)
                $display("mismatch %0d at %0t: %s, expected clash %0b, got %0b",
                         failures, $time, what, want, got);
        endfunction

        function void check_clash(logic got);
            logic want;
            results_seen++;
            if (got === 1'b1) clashes_seen++;
            if (expected_clash.size() == 0) begin
                flag_error("result with nothing pending", 1'bx, got);
                return;
            end
            want = expected_clash.pop_front();
            if (got !== want) flag_error("clash flag", want, got);
        endfunction

        function int pending_count();
            return expected_clash.size();
        endfunction
    endclass

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         i_valid;
    logic                         o_stall;
    logic                         i_cmd;
    logic [POS_W-1:0]             i_position;
    logic signed [COORD_BITS-1:0] i_coord_x;
    logic signed [COORD_BITS-1:0] i_coord_y;
    logic signed [COORD_BITS-1:0] i_coord_z;
    logic [KIND_W-1:0]            i_kind;
    logic [KIND_W-1:0]            i_partner_kind;
    logic [CLS_W-1:0]             i_sep_class;
    logic [LIMIT_W-1:0]           i_limit_value;
    logic                         o_valid;
    logic                         i_stall;
    logic                         o_clash;

    clash_scoreboard sb;

    // generator view of the chain: which positions hold an atom, and where
    bit                           chain_written[MAX_ATOMS];
    logic signed [COORD_BITS-1:0] walk_x[MAX_ATOMS];
    logic signed [COORD_BITS-1:0] walk_y[MAX_ATOMS];
    logic signed [COORD_BITS-1:0] walk_z[MAX_ATOMS];
    int                           chain_len      = 0;
    int                           items_accepted = 0;
    int                           n_writes       = 0;
    int                           n_places       = 0;
    int                           max_place      = 0;
    bit                           quiet_tail     = 1'b0;
    bit                           tx_calm        = 1'b0;

    chain_atom_clash_check_top u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_cmd          (i_cmd),
        .i_position     (i_position),
        .i_coord_x      (i_coord_x),
        .i_coord_y      (i_coord_y),
        .i_coord_z      (i_coord_z),
        .i_kind         (i_kind),
        .i_partner_kind (i_partner_kind),
        .i_sep_class    (i_sep_class),
        .i_limit_value  (i_limit_value),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_clash        (o_clash)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #6_000_000;
        $display("testbench: done, errors");
        $finish;
    end

    // table write item; the fields it ignores carry random bits
    function automatic t_chain_item make_write(logic [KIND_W-1:0] k, logic [KIND_W-1:0] pk,
                                               logic [CLS_W-1:0] cls, logic [LIMIT_W-1:0] lim);
        t_chain_item it;
        it.cmd          = CMD_WRITE;
        it.position     = POS_W'($urandom_range(0, MAX_ATOMS - 1));
        it.coord_x      = COORD_BITS'($urandom);
        it.coord_y      = COORD_BITS'($urandom);
        it.coord_z      = COORD_BITS'($urandom);
        it.kind         = k;
        it.partner_kind = pk;
        it.sep_class    = cls;
        it.limit_value  = lim;
        return it;
    endfunction

    // placement item; the fields it ignores carry random bits
    function automatic t_chain_item make_place(int p, int x, int y, int z,
                                               logic [KIND_W-1:0] k);
        t_chain_item it;
        it.cmd          = CMD_PLACE;
        it.position     = POS_W'(p);
        it.coord_x      = COORD_BITS'(x);
        it.coord_y      = COORD_BITS'(y);
        it.coord_z      = COORD_BITS'(z);
        it.kind         = k;
        it.partner_kind = KIND_W'($urandom_range(0, 3));
        it.sep_class    = CLS_W'($urandom_range(0, 3));
        it.limit_value  = LIMIT_W'($urandom);
        return it;
    endfunction

    // one random step of the chain walk, kept inside the coordinate range
    function automatic int walk_step(int base);
        int r;
        int v;
        r = $urandom_range(0, 2 * STEP);
        v = base + r - STEP;
        if (v > COORD_MAX) v = COORD_MAX;
        if (v < COORD_MIN) v = COORD_MIN;
        return v;
    endfunction

    // offer one item until accepted, then maybe pause
    task automatic send_item(input t_chain_item it);
        int gap;
        i_valid        <= 1'b1;
        i_cmd          <= it.cmd;
        i_position     <= it.position;
        i_coord_x      <= it.coord_x;
        i_coord_y      <= it.coord_y;
        i_coord_z      <= it.coord_z;
        i_kind         <= it.kind;
        i_partner_kind <= it.partner_kind;
        i_sep_class    <= it.sep_class;
        i_limit_value  <= it.limit_value;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sb.note_item(it);
        items_accepted++;
        if (it.cmd == CMD_PLACE) begin
            n_places++;
            if (int'(it.position) > max_place) max_place = it.position;
            chain_written[it.position] = 1'b1;
            walk_x[it.position] = it.coord_x;
            walk_y[it.position] = it.coord_y;
            walk_z[it.position] = it.coord_z;
            while (chain_len < MAX_ATOMS && chain_written[chain_len]) chain_len++;
        end else begin
            n_writes++;
        end
        // sender idle burst
        if (!quiet_tail && !tx_calm && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 7);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // extremes, ignored writes, threshold edges and the early positions
    task automatic run_directed();
        t_chain_item it;
        send_item(make_write(2'd0, 2'd0, CLS_14, LIMIT_MAX));
        send_item(make_write(2'd0, 2'd0, CLS_FAR, LIMIT_MAX));
        it = make_write(2'd2, 2'd2, CLS_FAR, '0);
        it.position = '1;
        send_item(it);
        // writes with an index out of range leave the table alone
        send_item(make_write(KIND_BAD, 2'd0, CLS_14, LIMIT_MAX));
        send_item(make_write(2'd0, KIND_BAD, CLS_15, LIMIT_MAX));
        send_item(make_write(2'd1, 2'd1, CLS_BAD, LIMIT_MAX));
        send_item(make_write(2'd0, 2'd1, CLS_15, 32'h4000_0000));
        // early positions never clash
        send_item(make_place(0, 0, 0, 0, 2'd0));
        send_item(make_place(1, COORD_MAX, COORD_MAX, COORD_MAX, 2'd1));
        send_item(make_place(2, COORD_MIN, COORD_MIN, COORD_MIN, 2'd2));
        // 1-4 pair one angstrom apart
        send_item(make_place(3, 4096, 0, 0, 2'd0));
        send_item(make_place(4, COORD_MAX - 4096, COORD_MAX, COORD_MAX, 2'd0));
        // far pair just beyond and just inside the axis limit
        send_item(make_place(5, 65536, 0, 0, 2'd0));
        send_item(make_place(5, 65535, 0, 0, 2'd0));
        // 1-5 pair near the top corner
        send_item(make_place(5, COORD_MAX - 4096, COORD_MAX, COORD_MAX, 2'd0));
        // unknown kind, then a kind whose thresholds are still zero
        send_item(make_place(6, 0, 0, 0, KIND_BAD));
        send_item(make_place(6, 0, 0, 0, 2'd2));
        send_item(make_write(2'd2, 2'd0, CLS_FAR, LIMIT_MAX));
        send_item(make_place(6, 0, 0, 0, 2'd2));
        // distance equal to the threshold, then one below it
        send_item(make_write(2'd1, 2'd0, CLS_14, ONE_SQ_A));
        send_item(make_place(3, 4096, 0, 0, 2'd1));
        send_item(make_write(2'd1, 2'd0, CLS_14, ONE_SQ_A + 1));
        send_item(make_place(3, 4096, 0, 0, 2'd1));
    endtask

    // random table write, mostly radii of a few angstrom
    task automatic random_write();
        logic [KIND_W-1:0]  k;
        logic [KIND_W-1:0]  pk;
        logic [CLS_W-1:0]   cls;
        logic [LIMIT_W-1:0] lim;
        int                 sel;
        if ($urandom_range(0, 9) == 0) begin
            k   = KIND_W'($urandom_range(0, 3));
            pk  = KIND_W'($urandom_range(0, 3));
            cls = CLS_W'($urandom_range(0, 3));
        end else begin
            k   = KIND_W'($urandom_range(0, NUM_KINDS - 1));
            pk  = KIND_W'($urandom_range(0, NUM_KINDS - 1));
            cls = CLS_W'($urandom_range(0, CLASS_COUNT - 1));
        end
        sel = $urandom_range(0, 19);
        if (sel < 14)
            lim = LIMIT_W'($urandom_range(0, 32'h2000_0000));
        else if (sel < 17)
            lim = LIMIT_W'($urandom_range(0, 32'h0400_0000));
        else
            lim = LIMIT_W'($urandom);
        send_item(make_write(k, pk, cls, lim));
    endtask

    // random placement: mostly grows or reshapes the chain as a walk
    task automatic random_place();
        int                hi;
        int                p;
        int                bx, by, bz;
        logic [KIND_W-1:0] k;
        hi = (chain_len + MIN_SEP - 1 < MAX_ATOMS - 1) ? chain_len + MIN_SEP - 1 : MAX_ATOMS - 1;
        k  = ($urandom_range(0, 49) == 0) ? KIND_BAD
                                          : KIND_W'($urandom_range(0, NUM_KINDS - 1));
        if ($urandom_range(0, 11) == 0) begin
            // noise: any reachable position, coordinates from the full range
            p = $urandom_range(0, hi);
            send_item(make_place(p, int'($urandom), int'($urandom), int'($urandom),
                                 KIND_W'($urandom_range(0, 3))));
        end else begin
            if (chain_len < MAX_ATOMS && (chain_len == 0 || $urandom_range(0, 9) < 7))
                p = chain_len;
            else
                p = $urandom_range(0, chain_len - 1);
            if (p == 0) begin
                bx = 0;
                by = 0;
                bz = 0;
            end else begin
                bx = walk_x[p-1];
                by = walk_y[p-1];
                bz = walk_z[p-1];
            end
            send_item(make_place(p, walk_step(bx), walk_step(by), walk_step(bz), k));
        end
    endtask

    // result monitor
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_valid === 1'b1 && i_stall === 1'b0)
            sb.check_clash(o_clash);
    end

    // receiver stalls: random bursts, calm stretches, one long hold-off
    initial begin : rx_side
        int cyc;
        bit rx_calm;
        bit held;
        cyc     = 0;
        rx_calm = 1'b0;
        held    = 1'b0;
        i_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            cyc++;
            if (cyc % 128 == 0) rx_calm = ($urandom_range(0, 3) == 0);
            if (!held && items_accepted >= HOLD_AT) begin
                held = 1'b1;
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                i_stall <= 1'b0;
            end else if (!quiet_tail && !rx_calm && $urandom_range(0, 5) == 0) begin
                i_stall <= 1'b1;
                repeat ($urandom_range(1, 7)) @(posedge i_clk);
                i_stall <= 1'b0;
            end
        end
    end

    // main sequence
    initial begin
        sb = new();
        i_rst_n        <= 1'b0;
        i_valid        <= 1'b0;
        i_cmd          <= CMD_WRITE;
        i_position     <= '0;
        i_coord_x      <= '0;
        i_coord_y      <= '0;
        i_coord_z      <= '0;
        i_kind         <= '0;
        i_partner_kind <= '0;
        i_sep_class    <= CLS_14;
        i_limit_value  <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        run_directed();

        // fill the whole table first, then mixed traffic
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 50 == 0) tx_calm = ($urandom_range(0, 3) == 0);
            quiet_tail = (n >= RANDOM_ITEMS - QUIET_ITEMS);
            if (n < TABLE_SIZE)
                send_item(make_write(KIND_W'(n / (NUM_KINDS * CLASS_COUNT)),
                                     KIND_W'((n / CLASS_COUNT) % NUM_KINDS),
                                     CLS_W'(n % CLASS_COUNT),
                                     LIMIT_W'($urandom_range(0, 32'h2000_0000))));
            else if ($urandom_range(0, 99) < 18)
                random_write();
            else
                random_place();
        end
        i_valid <= 1'b0;

        // drain
        while (sb.pending_count() > 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("summary: %0d table writes, %0d placements, chain of %0d atoms, top position %0d",
                 n_writes, n_places, chain_len, max_place);
        $display("summary: %0d results checked, %0d clashes flagged, %0d mismatches",
                 sb.results_seen, sb.clashes_seen, sb.failures);
        if (sb.failures == 0 && sb.pending_count() == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

endmodule

[chain_atom_clash_check_top.f]
hw/rtl/cacc_pkg.sv
hw/rtl/cacc_atom_mem.sv
hw/rtl/cacc_radius_table.sv
hw/rtl/cacc_dist_pipe.sv
hw/rtl/chain_atom_clash_check_top.sv
tb/testbench.sv
